[rtl/core/vcv_pkg.sv]
package vcv_pkg;

    // Widths of the payload and configuration fields
    localparam int CW_W     = 12;   // column width register
    localparam int NCOL_W   = 5;    // column count register
    localparam int FPD_W    = 4;    // frames per decision register
    localparam int CELL_W   = 5;    // win_col field
    localparam int VOTE_W   = 16;   // vote counters and best_votes field
    localparam int CFG_DATA_W = 12; // widest configuration register
    localparam int CFG_IDX_W  = 2;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [VOTE_W-1:0]     t_votes;

    // Configuration register indexes
    localparam t_cfg_idx CFG_COLUMN_WIDTH   = 2'd0;
    localparam t_cfg_idx CFG_NUM_COLUMNS    = 2'd1;
    localparam t_cfg_idx CFG_FRAMES_PER_DEC = 2'd2;

    // Request operation codes
    localparam logic OP_POINT     = 1'b0;
    localparam logic OP_FRAME_END = 1'b1;

    // Configuration reset values
    localparam logic [CW_W-1:0]   RST_COLUMN_WIDTH = 12'd64;
    localparam logic [NCOL_W-1:0] RST_NUM_COLUMNS  = 5'd7;
    localparam logic [FPD_W-1:0]  RST_FRAMES_PER_DEC = 4'd5;

    // Saturation level of a vote counter
    localparam t_votes VOTE_MAX = 16'hFFFF;

endpackage

[rtl/core/vcv_req_if.sv]
interface vcv_req_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [COORD_BITS-1:0] point_x;

    modport source (output valid, output operation, output point_x, input ready);
    modport sink   (input valid, input operation, input point_x, output ready);
endinterface

[rtl/core/vcv_res_if.sv]
interface vcv_res_if;
    import vcv_pkg::*;

    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] win_col;
    logic [VOTE_W-1:0] best_votes;

    modport source (output valid, output win_col, output best_votes, input ready);
    modport sink   (input valid, input win_col, input best_votes, output ready);
endinterface

[rtl/core/vanishing_column_vote_core.sv]
// Column vote histogram for line-intersection x coordinates. A point request
// bins point_x by the configured column width with a restoring divider that
// produces one quotient bit per cycle, then does a read-modify-write of the
// vote memory; a point that lands past the last column skips the write, and
// a zero column width skips the divider and counts nothing. An end-of-frame
// request that does not close the window only advances the frame count. A
// closing one scans the vote memory through its single read port, with a read
// state and a compare state per active column, and then loads the output
// register; the scan is skipped when no points arrived or no column is active,
// and the load waits while an earlier result is still untaken. A new request
// is taken while a loaded result waits. The histogram is cleared at once
// through per-column valid bits, so there is no clearing pass after reset.
// The user must write configuration only while idle; the block itself does
// not enforce it.
module vanishing_column_vote_core #(
    parameter int MAX_COLUMNS = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    vcv_req_if.sink            i_req,
    vcv_res_if.source          o_res,
    input  logic               i_cfg_we,
    input  vcv_pkg::t_cfg_idx  i_cfg_idx,
    input  vcv_pkg::t_cfg_data i_cfg_data
);
    import vcv_pkg::*;

    localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CNTC_W = $clog2(MAX_COLUMNS + 1);
    localparam int ACT_W = (CNTC_W > NCOL_W) ? CNTC_W : NCOL_W;
    localparam int CMP_W = (COORD_BITS > ACT_W) ? COORD_BITS : ACT_W;
    localparam int DCNT_W = $clog2(COORD_BITS + 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_LOOK = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_SRD  = 3'd4;
    localparam logic [2:0] ST_SCMP = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    // Configuration registers
    logic [CW_W-1:0]   r_col_width;
    logic [NCOL_W-1:0] r_num_cols;
    logic [FPD_W-1:0]  r_fpd;

    // Control and datapath registers
    logic [2:0]             r_state, n_state;
    logic                   r_seen, n_seen;
    logic [FPD_W-1:0]       r_frame, n_frame;
    logic [MAX_COLUMNS-1:0] r_vld, n_vld;
    logic [CW_W-1:0]        r_rem, n_rem;
    logic [COORD_BITS-1:0]  r_quo, n_quo;
    logic [DCNT_W-1:0]      r_cnt, n_cnt;
    logic [ACT_W-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]       r_best, n_best;
    t_votes                 r_bvotes, n_bvotes;
    logic [CELL_W-1:0]      r_bcell, n_bcell;
    logic                   r_out_valid, n_out_valid;
    logic [CELL_W-1:0]      r_out_cell, n_out_cell;
    t_votes                 r_out_votes, n_out_votes;

    // Vote memory
    t_votes           r_mem [MAX_COLUMNS];
    t_votes           r_rd_data;
    logic             r_rd_vld;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    t_votes           mem_wdata;

    // Combinational helpers
    logic [ACT_W-1:0]  active;
    logic [CW_W:0]     div_sh;
    logic              div_ge;
    logic [CW_W:0]     div_diff;
    logic              in_range;
    t_votes            rd_val;
    logic [FPD_W-1:0]  limit;
    logic [FPD_W-1:0]  frame_inc;
    logic              upd_best;
    logic [IDX_W-1:0]  scan_best;
    t_votes            scan_votes;
    logic              req_acc;

    assign active = (ACT_W'(r_num_cols) > ACT_W'(MAX_COLUMNS)) ?
                    ACT_W'(MAX_COLUMNS) : ACT_W'(r_num_cols);

    // One restoring divide step
    assign div_sh   = {r_rem, r_quo[COORD_BITS-1]};
    assign div_ge   = div_sh >= {1'b0, r_col_width};
    assign div_diff = div_sh - {1'b0, r_col_width};

    assign in_range  = CMP_W'(r_quo) < CMP_W'(active);
    assign rd_val    = r_rd_vld ? r_rd_data : '0;
    assign limit     = (r_fpd == '0) ? FPD_W'(1) : r_fpd;
    assign frame_inc = r_frame + FPD_W'(1);

    assign upd_best   = rd_val > r_bvotes;
    assign scan_best  = upd_best ? r_idx[IDX_W-1:0] : r_best;
    assign scan_votes = upd_best ? rd_val : r_bvotes;

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;

    assign o_res.valid      = r_out_valid;
    assign o_res.win_col    = r_out_cell;
    assign o_res.best_votes = r_out_votes;

    assign rd_addr = (r_state == ST_LOOK) ? r_quo[IDX_W-1:0] : r_idx[IDX_W-1:0];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_width <= RST_COLUMN_WIDTH;
            r_num_cols  <= RST_NUM_COLUMNS;
            r_fpd       <= RST_FRAMES_PER_DEC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLUMN_WIDTH:   r_col_width <= i_cfg_data[CW_W-1:0];
                CFG_NUM_COLUMNS:    r_num_cols  <= i_cfg_data[NCOL_W-1:0];
                CFG_FRAMES_PER_DEC: r_fpd       <= i_cfg_data[FPD_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_seen      = r_seen;
        n_frame     = r_frame;
        n_vld       = r_vld;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_best      = r_best;
        n_bvotes    = r_bvotes;
        n_bcell     = r_bcell;
        n_out_valid = r_out_valid;
        n_out_cell  = r_out_cell;
        n_out_votes = r_out_votes;
        mem_we      = 1'b0;
        mem_wdata   = rd_val + VOTE_W'(1);

        // Drop the result once it is taken
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    if (i_req.operation == OP_POINT) begin
                        n_seen = 1'b1;
                        if (r_col_width != '0) begin
                            n_rem   = '0;
                            n_quo   = i_req.point_x;
                            n_cnt   = DCNT_W'(COORD_BITS);
                            n_state = ST_DIV;
                        end
                    end else if (frame_inc < limit) begin
                        n_frame = frame_inc;
                    end else if (!r_seen) begin
                        // No points in this window
                        n_bcell  = '0;
                        n_bvotes = '0;
                        n_state  = ST_DONE;
                    end else begin
                        n_idx    = '0;
                        n_best   = '0;
                        n_bvotes = '0;
                        if (active == '0) begin
                            n_bcell = CELL_W'(1);
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_SRD;
                        end
                    end
                end
            end
            ST_DIV: begin
                n_rem = div_ge ? div_diff[CW_W-1:0] : div_sh[CW_W-1:0];
                n_quo = {r_quo[COORD_BITS-2:0], div_ge};
                n_cnt = r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = in_range ? ST_UPD : ST_IDLE;
            end
            ST_UPD: begin
                // Count the vote unless the column is saturated
                if (rd_val != VOTE_MAX) begin
                    mem_we = 1'b1;
                    n_vld[r_quo[IDX_W-1:0]] = 1'b1;
                end
                n_state = ST_IDLE;
            end
            ST_SRD: begin
                n_state = ST_SCMP;
            end
            ST_SCMP: begin
                n_best   = scan_best;
                n_bvotes = scan_votes;
                n_idx    = r_idx + ACT_W'(1);
                if (ACT_W'(r_idx + ACT_W'(1)) == active) begin
                    n_bcell = CELL_W'(ACT_W'(scan_best) + ACT_W'(1));
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SRD;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_cell  = r_bcell;
                    n_out_votes = r_bvotes;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Clear the window as the decision is closed
        if (n_state == ST_DONE && r_state != ST_DONE) begin
            n_vld   = '0;
            n_seen  = 1'b0;
            n_frame = '0;
        end
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seen      <= 1'b0;
            r_frame     <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_frame     <= n_frame;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold datapath values
    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_cnt       <= n_cnt;
        r_idx       <= n_idx;
        r_best      <= n_best;
        r_bvotes    <= n_bvotes;
        r_bcell     <= n_bcell;
        r_out_cell  <= n_out_cell;
        r_out_votes <= n_out_votes;
    end

    // Vote memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_quo[IDX_W-1:0]] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
    end

`ifndef NO_ASSERTIONS
    // A result without points carries no votes
    a_empty_no_votes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cell == '0) |-> (r_out_votes == '0))
        else $error("empty decision carries votes");

    // A point with a nonzero column width starts the divider
    a_point_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.operation == OP_POINT && r_col_width != '0)
        |=> (r_state == ST_DIV && r_cnt == DCNT_W'(COORD_BITS)))
        else $error("point request did not start the divider");

    // The window is clear while a decision waits for the output register
    a_window_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_frame == '0 && !r_seen && r_vld == '0))
        else $error("window not cleared at decision");

    // A loaded result is never overwritten before it is taken
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> (r_out_valid && $stable(r_out_cell)
            && $stable(r_out_votes)))
        else $error("pending result overwritten");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import vcv_pkg::*;

    localparam int MAX_COLUMNS    = 16;
    localparam int COORD_BITS     = 12;
    localparam int SETTLE_CYCLES  = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 140;

    typedef struct packed {
        logic [CELL_W-1:0] col_id;
        t_votes            votes;
    } t_decision;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic                  op;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic [16:0]           reps;
        logic                  pinned;
        t_decision             result;
    } t_stim_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we;
    t_cfg_idx  cfg_idx;
    t_cfg_data cfg_data;

    vcv_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
    vcv_res_if res_bus ();

    vanishing_column_vote_core #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_req     (req_bus),
        .o_res     (res_bus),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // Shadow of the configuration and the vote window
    logic [CW_W-1:0]   cfg_col_width;
    logic [NCOL_W-1:0] cfg_num_cols;
    logic [FPD_W-1:0]  cfg_frames;
    t_votes            hist_votes [MAX_COLUMNS];
    logic              hist_seen;
    logic [FPD_W-1:0]  hist_frames;

    t_decision   decision_queue [$];
    t_stim_row   stim_rows [$];
    int          mismatch_count = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    int unsigned stall_cycles = 0;

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int unsigned active_cols();
        return (cfg_num_cols > NCOL_W'(MAX_COLUMNS)) ? MAX_COLUMNS : 32'(cfg_num_cols);
    endfunction

    function automatic void clear_window();
        foreach (hist_votes[i]) hist_votes[i] = '0;
        hist_seen   = 1'b0;
        hist_frames = '0;
    endfunction

    // Bin a point or close a frame; report a decision when the window ends
    task automatic tally_request(input logic op, input logic [COORD_BITS-1:0] x,
                                 output logic decided, output t_decision d);
        int unsigned col;
        int unsigned limit;
        int unsigned best;
        decided = 1'b0;
        d       = '0;
        if (op == OP_POINT) begin
            hist_seen = 1'b1;
            if (cfg_col_width != 0) begin
                col = 32'(x) / 32'(cfg_col_width);
                if (col < active_cols() && hist_votes[col] != VOTE_MAX)
                    hist_votes[col]++;
            end
        end else begin
            limit       = (cfg_frames == '0) ? 1 : 32'(cfg_frames);
            hist_frames = hist_frames + 1'b1;
            if (hist_frames >= limit) begin
                decided = 1'b1;
                if (hist_seen) begin
                    best = 0;
                    for (int i = 0; i < active_cols(); i++) begin
                        if (hist_votes[i] > d.votes) begin
                            d.votes = hist_votes[i];
                            best    = i;
                        end
                    end
                    d.col_id = CELL_W'(best + 1);
                end
                clear_window();
            end
        end
    endtask

    // Offer one request, with random hold-off, and predict once it is taken
    task automatic push_request(input logic op, input logic [COORD_BITS-1:0] x,
                                input logic pinned, input t_decision pin_val);
        logic      decided;
        t_decision d;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_bus.valid = 1'b0;
            @(negedge clk);
        end
        req_bus.valid     = 1'b1;
        req_bus.operation = op;
        req_bus.point_x   = x;
        do @(posedge clk); while (!req_bus.ready);
        tally_request(op, x, decided, d);
        if (decided || pinned)
            decision_queue = {decision_queue, (pinned ? pin_val : d)};
    endtask

    // Drain all decisions and let a trailing point finish before a register write
    task automatic settle();
        @(negedge clk);
        req_bus.valid = 1'b0;
        while (decision_queue.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = t_cfg_data'(data);
        case (idx)
            CFG_COLUMN_WIDTH:   cfg_col_width = cfg_data[CW_W-1:0];
            CFG_NUM_COLUMNS:    cfg_num_cols  = cfg_data[NCOL_W-1:0];
            CFG_FRAMES_PER_DEC: cfg_frames    = cfg_data[FPD_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic void add_req(input logic op, input logic [COORD_BITS-1:0] x,
                                    input int reps);
        t_stim_row r;
        r       = '0;
        r.kind  = ROW_REQ;
        r.op    = op;
        r.value = x;
        r.reps  = 17'(reps);
        stim_rows = {stim_rows, r};
    endfunction

    // Frame end whose decision is known by inspection
    function automatic void add_decision(input int col, input int votes);
        t_stim_row r;
        r               = '0;
        r.kind          = ROW_REQ;
        r.op            = OP_FRAME_END;
        r.value         = 12'hFFF;
        r.reps          = 17'd1;
        r.pinned        = 1'b1;
        r.result.col_id = CELL_W'(col);
        r.result.votes  = VOTE_W'(votes);
        stim_rows = {stim_rows, r};
    endfunction

    function automatic void add_cfg(input t_cfg_idx idx, input int value);
        t_stim_row r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.value   = CFG_DATA_W'(value);
        stim_rows = {stim_rows, r};
    endfunction

    // Compare each delivered decision with the oldest prediction
    always @(posedge clk) begin
        t_decision want;
        if (rst_n && res_bus.valid && res_bus.ready) begin
            if (decision_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected decision column %0d votes %0d",
                                          res_bus.win_col, res_bus.best_votes));
            end else begin
                want = decision_queue.pop_front();
                if (res_bus.win_col !== want.col_id)
                    report_mismatch($sformatf("win_col got %0d expected %0d",
                                              res_bus.win_col, want.col_id));
                if (res_bus.best_votes !== want.votes)
                    report_mismatch($sformatf("best_votes got %0d expected %0d",
                                              res_bus.best_votes, want.votes));
            end
        end
    end

    // Randomly stall the result side
    always @(negedge clk) begin
        res_bus.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        logic [COORD_BITS-1:0] x;
        logic                  op;
        int                    span;
        int                    fe_pct;
        int                    keep_send;
        int                    keep_recv;
        t_stim_row             row;

        req_bus.valid     = 1'b0;
        req_bus.operation = OP_POINT;
        req_bus.point_x   = '0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_COLUMN_WIDTH;
        cfg_data          = '0;
        send_idle_pct     = 19;
        recv_idle_pct     = 67;

        cfg_col_width = RST_COLUMN_WIDTH;
        cfg_num_cols  = RST_NUM_COLUMNS;
        cfg_frames    = RST_FRAMES_PER_DEC;
        clear_window();

        // Empty window at reset settings: five frames, no points
        repeat (4) add_req(OP_FRAME_END, 12'h000, 1);
        add_decision(0, 0);
        // One counted point, one past the last column
        add_cfg(CFG_FRAMES_PER_DEC, 1);
        add_req(OP_POINT, 12'd0, 1);
        add_req(OP_POINT, 12'd4095, 1);
        add_decision(1, 1);
        // Only uncounted points still give a decision
        add_req(OP_POINT, 12'd4095, 1);
        add_decision(1, 0);
        // Zero column width counts nothing
        add_cfg(CFG_COLUMN_WIDTH, 0);
        add_req(OP_POINT, 12'd100, 1);
        add_decision(1, 0);
        // Widest columns, all of them
        add_cfg(CFG_COLUMN_WIDTH, 4095);
        add_cfg(CFG_NUM_COLUMNS, 16);
        add_req(OP_POINT, 12'd4095, 1);
        add_req(OP_POINT, 12'd0, 1);
        add_req(OP_POINT, 12'd4094, 1);
        add_decision(1, 2);
        // No columns at all
        add_cfg(CFG_NUM_COLUMNS, 0);
        add_req(OP_POINT, 12'd5, 1);
        add_decision(1, 0);
        // Column count above the maximum, unit width, tie goes to the first
        add_cfg(CFG_NUM_COLUMNS, 31);
        add_cfg(CFG_COLUMN_WIDTH, 1);
        add_req(OP_POINT, 12'd15, 1);
        add_req(OP_POINT, 12'd16, 1);
        add_req(OP_POINT, 12'd3, 1);
        add_decision(4, 1);
        // Zero frames per decision acts as one
        add_cfg(CFG_FRAMES_PER_DEC, 0);
        add_decision(0, 0);
        // Lower the frame limit to the running count
        add_cfg(CFG_FRAMES_PER_DEC, 15);
        repeat (2) add_req(OP_FRAME_END, 12'h000, 1);
        add_cfg(CFG_FRAMES_PER_DEC, 2);
        add_decision(0, 0);
        // Back-to-back points into one column
        add_cfg(CFG_COLUMN_WIDTH, 4095);
        add_cfg(CFG_NUM_COLUMNS, 1);
        add_cfg(CFG_FRAMES_PER_DEC, 1);
        add_req(OP_POINT, 12'd4094, 40);
        add_decision(1, 40);

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed rows
        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.reg_idx, int'(row.value));
            end else begin
                // Run long bursts at full rate
                keep_send = send_idle_pct;
                keep_recv = recv_idle_pct;
                if (row.reps > 1) begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                repeat (row.reps) push_request(row.op, row.value, row.pinned, row.result);
                send_idle_pct = keep_send;
                recv_idle_pct = keep_recv;
            end
        end

        // Random windows under three idling modes, fresh settings per window
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 19; recv_idle_pct = 67; end
                1: begin send_idle_pct = 67; recv_idle_pct = 19; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int w = 0; w < 4; w++) begin
                settle();
                case ($urandom_range(0, 7))
                    0: write_reg(CFG_COLUMN_WIDTH, 0);
                    1: write_reg(CFG_COLUMN_WIDTH, 1);
                    2: write_reg(CFG_COLUMN_WIDTH, 4095);
                    3, 4, 5: write_reg(CFG_COLUMN_WIDTH, int'($urandom_range(1, 700)));
                    default: write_reg(CFG_COLUMN_WIDTH, int'($urandom_range(0, 4095)));
                endcase
                case ($urandom_range(0, 5))
                    0: write_reg(CFG_NUM_COLUMNS, 0);
                    1: write_reg(CFG_NUM_COLUMNS, 1);
                    2: write_reg(CFG_NUM_COLUMNS, 16);
                    3: write_reg(CFG_NUM_COLUMNS, 31);
                    default: write_reg(CFG_NUM_COLUMNS, int'($urandom_range(0, 31)));
                endcase
                case ($urandom_range(0, 5))
                    0: write_reg(CFG_FRAMES_PER_DEC, 0);
                    1: write_reg(CFG_FRAMES_PER_DEC, 1);
                    2: write_reg(CFG_FRAMES_PER_DEC, 15);
                    default: write_reg(CFG_FRAMES_PER_DEC, int'($urandom_range(0, 15)));
                endcase
                case ($urandom_range(0, 2))
                    0: fe_pct = 8;
                    1: fe_pct = 25;
                    default: fe_pct = 50;
                endcase
                // Keep most points inside the active columns
                span = int'(cfg_col_width) * int'(active_cols()) + int'(cfg_col_width) / 2;
                if (span > 4095) span = 4095;
                for (int k = 0; k < RANDOM_ITEMS; k++) begin
                    op = ($urandom_range(0, 99) < fe_pct) ? OP_FRAME_END : OP_POINT;
                    if (cfg_col_width == 0 || $urandom_range(0, 99) < 15)
                        x = COORD_BITS'($urandom_range(0, 4095));
                    else
                        x = COORD_BITS'($urandom_range(0, span));
                    push_request(op, x, 1'b0, '0);
                end
            end
        end

        // Drain and let the block go quiet
        @(negedge clk);
        req_bus.valid = 1'b0;
        while (decision_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
